### rtl/brt_pkg.sv
`default_nettype none

package brt_pkg;

  localparam int unsigned TimeW  = 40;
  localparam int unsigned BytesW = 32;
  localparam int unsigned LimitW = 32;
  localparam int unsigned WaitW  = 32;
  localparam int unsigned WinW   = 40;

  // window_bytes * 1000 stays below 2^50
  localparam int unsigned ProdW  = 50;
  localparam int unsigned ElapW  = 10;

  localparam int unsigned MsPerSec = 1000;
  localparam int unsigned DivSteps = ProdW;
  localparam int unsigned CntW     = $clog2(DivSteps);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PREP = 7'b0000010,
    S_ACC  = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_CMP  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_FIN  = 7'b1000000
  } brt_state_e;

endpackage

`default_nettype wire

### rtl/brt_in_if.sv
`default_nettype none

interface brt_in_if import brt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TimeW-1:0]  now_ms;
  logic [BytesW-1:0] byte_count;

  modport source (output valid, output now_ms, output byte_count, input ready);
  modport sink   (input valid, input now_ms, input byte_count, output ready);
endinterface

`default_nettype wire

### rtl/brt_out_if.sv
`default_nettype none

interface brt_out_if import brt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             allowed;
  logic [WaitW-1:0] wait_ms;

  modport source (output valid, output allowed, output wait_ms, input ready);
  modport sink   (input valid, input allowed, input wait_ms, output ready);
endinterface

`default_nettype wire

### rtl/byte_rate_throttle_core.sv
`default_nettype none

// an item with a nonzero limit passes S_PREP, S_ACC, S_MUL, S_CMP, the bit-serial restoring
//   divider in S_DIV and S_FIN; with a zero limit (throttling off) it goes from S_IDLE to S_FIN
// no new item is taken until S_FIN has written the previous result to the output register;
//   the divider makes one quotient bit per cycle over the 50-bit byte*1000 product
// a new item is taken while the previous result still waits in the output register
// reset (async, active low) clears the window start, the byte count and the limit
module byte_rate_throttle_core import brt_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [LimitW-1:0] cfg_wdata_i,
  brt_in_if.sink                 in_i,
  brt_out_if.source              out_o
);

  // configuration
  logic [LimitW-1:0] rate_limit_q;

  // window state
  logic [TimeW-1:0]  win_start_q, win_start_d;
  logic [WinW-1:0]   win_bytes_q, win_bytes_d;

  // item registers
  logic [TimeW-1:0]  now_q, now_d;
  logic [BytesW-1:0] bytes_q, bytes_d;
  logic [ElapW-1:0]  elap_q, elap_d;

  // product, compare and divider
  logic [ProdW-1:0]         pq_q, pq_d;       // dividend in, quotient out
  logic [LimitW-1:0]        rem_q, rem_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [LimitW+ElapW:0]    prod_q, prod_d;   // (limit+1)*elapsed, 43 bits
  logic                     rate_gt_q, rate_gt_d;
  logic                     deny0_q, deny0_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic              allowed_q, allowed_d;
  logic [WaitW-1:0]  wait_q, wait_d;

  brt_state_e state_q, state_d;

  // combinational helpers
  logic [TimeW-1:0]  diff;
  logic              backwards;
  logic              restart;
  logic [WinW:0]     sum;
  logic [LimitW:0]   lim_p1;
  logic [LimitW:0]   trial;
  logic [LimitW:0]   trial_sub;
  logic              trial_ge;
  logic [ProdW-1:0]  w_val;
  logic              deny;
  logic              out_free;

  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.allowed = allowed_q;
  assign out_o.wait_ms = wait_q;

  assign out_free  = !out_valid_q || out_o.ready;

  // time going backwards counts as no elapsed time, and never restarts the window here
  assign backwards = now_q < win_start_q;
  assign diff      = now_q - win_start_q;
  assign restart   = !backwards && (diff > TimeW'(MsPerSec));

  // byte count saturates at the window counter width
  assign sum       = {1'b0, win_bytes_q} + {{(WinW + 1 - BytesW){1'b0}}, bytes_q};
  assign lim_p1    = {1'b0, rate_limit_q} + {{LimitW{1'b0}}, 1'b1};

  // restoring division step: shift one dividend bit into the remainder
  assign trial     = {rem_q, pq_q[ProdW-1]};
  assign trial_ge  = trial >= {1'b0, rate_limit_q};
  assign trial_sub = trial - {1'b0, rate_limit_q};

  // decision from quotient (maxtime) and elapsed time
  always_comb begin
    w_val = '0;
    deny  = 1'b0;
    if (rate_limit_q == '0) begin
      deny = 1'b0;
    end else if (elap_q != '0) begin
      // floor(P/e) > limit is P >= (limit+1)*e
      if (rate_gt_q && (pq_q > {{(ProdW-ElapW){1'b0}}, elap_q})) begin
        w_val = pq_q - {{(ProdW-ElapW){1'b0}}, elap_q};
      end
      deny = (w_val != '0);
    end else begin
      w_val = pq_q;
      deny  = deny0_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    win_start_d = win_start_q;
    win_bytes_d = win_bytes_q;
    now_d       = now_q;
    bytes_d     = bytes_q;
    elap_d      = elap_q;
    pq_d        = pq_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    prod_d      = prod_q;
    rate_gt_d   = rate_gt_q;
    deny0_d     = deny0_q;
    out_valid_d = out_valid_q;
    allowed_d   = allowed_q;
    wait_d      = wait_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          now_d   = in_i.now_ms;
          bytes_d = in_i.byte_count;
          // zero limit: allow and leave the window alone
          state_d = (rate_limit_q == '0) ? S_FIN : S_PREP;
        end
      end
      S_PREP: begin
        if (restart) begin
          win_start_d = now_q;
          win_bytes_d = '0;
          elap_d      = '0;
        end else if (backwards) begin
          elap_d = '0;
        end else begin
          elap_d = diff[ElapW-1:0];
        end
        state_d = S_ACC;
      end
      S_ACC: begin
        win_bytes_d = sum[WinW] ? {WinW{1'b1}} : sum[WinW-1:0];
        state_d     = S_MUL;
      end
      S_MUL: begin
        pq_d    = {{(ProdW-WinW){1'b0}}, win_bytes_q} * ProdW'(MsPerSec);
        prod_d  = {{ElapW{1'b0}}, lim_p1} * {{(LimitW+1){1'b0}}, elap_q};
        deny0_d = (elap_q == '0) && (win_bytes_q >= {{(WinW-LimitW){1'b0}}, rate_limit_q});
        // burst with no elapsed time: deny and restart the window
        if ((elap_q == '0) && (win_bytes_q >= {{(WinW-LimitW){1'b0}}, rate_limit_q})) begin
          win_bytes_d = '0;
          win_start_d = now_q;
        end
        rem_d   = '0;
        cnt_d   = '0;
        state_d = S_CMP;
      end
      S_CMP: begin
        rate_gt_d = pq_q >= {{(ProdW-LimitW-ElapW-1){1'b0}}, prod_q};
        state_d   = S_DIV;
      end
      S_DIV: begin
        rem_d = trial_ge ? trial_sub[LimitW-1:0] : trial[LimitW-1:0];
        pq_d  = {pq_q[ProdW-2:0], trial_ge};
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(DivSteps - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          allowed_d   = !deny;
          if (!deny) begin
            wait_d = '0;
          end else if (w_val[ProdW-1:WaitW] != '0) begin
            wait_d = {WaitW{1'b1}};
          end else begin
            wait_d = w_val[WaitW-1:0];
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rate_limit_q <= '0;
      win_start_q  <= '0;
      win_bytes_q  <= '0;
      out_valid_q  <= 1'b0;
      cnt_q        <= '0;
    end else begin
      state_q     <= state_d;
      win_start_q <= win_start_d;
      win_bytes_q <= win_bytes_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      if (cfg_we_i) begin
        rate_limit_q <= cfg_wdata_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    now_q     <= now_d;
    bytes_q   <= bytes_d;
    elap_q    <= elap_d;
    pq_q      <= pq_d;
    rem_q     <= rem_d;
    prod_q    <= prod_d;
    rate_gt_q <= rate_gt_d;
    deny0_q   <= deny0_d;
    allowed_q <= allowed_d;
    wait_q    <= wait_d;
  end

endmodule

`default_nettype wire

### tb/byte_rate_throttle_monitor.sv
`timescale 1ns / 1ps

// watches the config port and both channels, predicts each decision and
// compares it with what the block returns
module byte_rate_throttle_monitor import brt_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [LimitW-1:0] cfg_wdata_i,
  input  wire logic              in_valid_i,
  input  wire logic              in_ready_i,
  input  wire logic [TimeW-1:0]  now_ms_i,
  input  wire logic [BytesW-1:0] byte_count_i,
  input  wire logic              out_valid_i,
  input  wire logic              out_ready_i,
  input  wire logic              allowed_i,
  input  wire logic [WaitW-1:0]  wait_ms_i,
  output int                     errors_o,
  output int                     pending_o
);

  typedef struct packed {
    logic             allowed;
    logic [WaitW-1:0] wait_ms;
  } decision_t;

  localparam logic [63:0] WinMax  = (64'd1 << WinW) - 64'd1;
  localparam logic [63:0] WaitMax = (64'd1 << WaitW) - 64'd1;

  logic [LimitW-1:0] limit_q;
  logic [TimeW-1:0]  win_start_q;
  logic [WinW-1:0]   win_bytes_q;
  decision_t         expected_decisions[$];
  int                err_count;

  function automatic logic [WaitW-1:0] clip_wait(input logic [63:0] v);
    return (v > WaitMax) ? WaitMax[WaitW-1:0] : v[WaitW-1:0];
  endfunction

  // advances the window state by one transfer and returns the decision
  function automatic decision_t predict_decision(input logic [TimeW-1:0]  now,
                                                 input logic [BytesW-1:0] nbytes);
    logic [63:0] elapsed;
    logic [63:0] total;
    logic [63:0] maxtime;
    logic [63:0] rate;
    logic [63:0] slack;
    decision_t   d;
    d.allowed = 1'b1;
    d.wait_ms = '0;
    if (limit_q == '0) return d;
    // time going backwards counts as no elapsed time
    elapsed = (now < win_start_q) ? 64'd0 : 64'(now - win_start_q);
    if (elapsed > 64'(MsPerSec)) begin
      win_start_q = now;
      win_bytes_q = '0;
      elapsed     = 64'd0;
    end
    total = 64'(win_bytes_q) + 64'(nbytes);
    if (total > WinMax) total = WinMax;
    win_bytes_q = total[WinW-1:0];
    maxtime = (total * 64'(MsPerSec)) / 64'(limit_q);
    if (elapsed != 64'd0) begin
      rate = (total * 64'(MsPerSec)) / elapsed;
      if (rate > 64'(limit_q)) begin
        slack = (maxtime > elapsed) ? maxtime - elapsed : 64'd0;
        if (slack != 64'd0) begin
          d.allowed = 1'b0;
          d.wait_ms = clip_wait(slack);
        end
      end
    end else if (total >= 64'(limit_q)) begin
      d.allowed   = 1'b0;
      d.wait_ms   = clip_wait(maxtime);
      win_bytes_q = '0;
      win_start_q = now;
    end
    return d;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    decision_t exp_d;
    if (!rst_ni) begin
      limit_q     = '0;
      win_start_q = '0;
      win_bytes_q = '0;
      expected_decisions.delete();
      err_count   = 0;
      errors_o    <= 0;
      pending_o   <= 0;
    end else begin
      if (cfg_we_i) limit_q = cfg_wdata_i;
      // results are checked before the new item is queued
      if (out_valid_i && out_ready_i) begin
        if (expected_decisions.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result: expected none, got allowed=%0d wait_ms=%0d",
                   $time, allowed_i, wait_ms_i);
        end else begin
          exp_d = expected_decisions.pop_front();
          if (allowed_i !== exp_d.allowed) begin
            err_count++;
            $display("%0t: allowed mismatch: expected %0d, got %0d",
                     $time, exp_d.allowed, allowed_i);
          end
          if (wait_ms_i !== exp_d.wait_ms) begin
            err_count++;
            $display("%0t: wait_ms mismatch: expected %0d, got %0d",
                     $time, exp_d.wait_ms, wait_ms_i);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_decisions.push_back(predict_decision(now_ms_i, byte_count_i));
      errors_o  <= err_count;
      pending_o <= expected_decisions.size();
    end
  end

endmodule

### tb/byte_rate_throttle_core_tb.sv
`timescale 1ns / 1ps

module byte_rate_throttle_core_tb;
  import brt_pkg::*;

  // cycles with no handshake on either channel before the run is abandoned
  localparam int StallLimit = 3000;
  localparam int TailCycles = 60;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [LimitW-1:0] cfg_wdata;
  logic [TimeW-1:0]  clock_ms;
  bit                no_idle;
  int                errors;
  int                pending;
  int                idle_cycles = 0;

  brt_in_if  in_ch ();
  brt_out_if out_ch ();

  byte_rate_throttle_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  byte_rate_throttle_monitor mon (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_ch.valid),
    .in_ready_i  (in_ch.ready),
    .now_ms_i    (in_ch.now_ms),
    .byte_count_i(in_ch.byte_count),
    .out_valid_i (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .allowed_i   (out_ch.allowed),
    .wait_ms_i   (out_ch.wait_ms),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // offers one transfer after a random gap and holds it until taken
  task automatic send_transfer(input logic [TimeW-1:0] now, input logic [BytesW-1:0] nbytes);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.now_ms     <= now;
    in_ch.byte_count <= nbytes;
    do @(posedge clk); while (!in_ch.ready);
    clock_ms = now;
  endtask

  // stops sending until every decision is back, then lets the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // the limit is only changed with the block idle
  task automatic set_limit(input logic [LimitW-1:0] lim);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly non-decreasing time with byte counts scaled to the limit,
  // mixed with jumps anywhere in the 40-bit range as noise
  task automatic run_phase(input logic [LimitW-1:0] lim, input int n, input bit calm);
    logic [TimeW-1:0]  t;
    logic [BytesW-1:0] b;
    logic [31:0]       span;
    int                sel;
    set_limit(lim);
    no_idle = calm;
    span = (lim != '0) ? lim / 3 + 1 : 32'd5000;
    for (int k = 0; k < n; k++) begin
      // hold the sender once mid-phase until all decisions are back
      if (k == n / 2) drain();
      sel = $urandom_range(0, 99);
      if (sel < 8)       t = {8'($urandom), 32'($urandom)};
      else if (sel < 14) t = clock_ms + 40'($urandom_range(1001, 4000));
      else if (sel < 18) t = clock_ms + 40'($urandom_range(999, 1002));
      else if (sel < 26) t = clock_ms;
      else               t = clock_ms + 40'($urandom_range(1, 300));
      case ($urandom_range(0, 9))
        0:       b = '0;
        1:       b = $urandom;
        2:       b = '1;
        default: b = $urandom_range(0, span);
      endcase
      send_transfer(t, b);
    end
    no_idle = 1'b0;
  endtask

  // a burst of maximum transfers inside one window drives the byte count
  // into saturation
  task automatic run_flood(input int n);
    logic [TimeW-1:0] t;
    set_limit('1);
    t = clock_ms + 40'd2000;
    for (int k = 0; k < n; k++) begin
      send_transfer(t, (k % 10 == 9) ? 32'($urandom) : '1);
      t = t + 40'($urandom_range(0, 3));
    end
  endtask

  // receiver: random stall before each result
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.now_ms     = '0;
    in_ch.byte_count = '0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    rst_n            = 1'b0;
    clock_ms         = '0;
    no_idle          = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // throttling off after reset: everything allowed, state untouched
    send_transfer('1, '1);
    send_transfer('0, '0);

    set_limit(32'd1000);
    send_transfer(40'd100, 32'd50);     // under the rate
    send_transfer(40'd200, 32'd500);    // over the rate, denied
    send_transfer(40'd550, 32'd0);      // exactly at the rate
    send_transfer(40'd600, 32'd100);    // over again
    send_transfer(40'd1000, 32'd0);     // a full second, window kept
    send_transfer(40'd1001, 32'd10);    // just past a second, window restarts
    send_transfer(40'd1001, 32'd2000);  // no elapsed time, limit reached
    send_transfer(40'd900, 32'd5000);   // time going backwards

    set_limit(32'd999);
    send_transfer(40'd5000, 32'd0);
    send_transfer(40'd5001, 32'd1);     // over the rate but zero wait left

    set_limit(32'd1);
    send_transfer(40'd7000, '1);        // wait saturates

    set_limit('1);
    send_transfer(40'd9000, '1);
    send_transfer(40'd9001, '1);
    send_transfer('1, 32'd1);

    run_phase(32'd1, 150, 1'b0);
    run_phase(32'd1000, 250, 1'b0);
    run_phase(32'($urandom_range(2, 100)), 200, 1'b0);
    run_phase(32'($urandom_range(1000, 1000000)), 250, 1'b1);
    run_phase(32'($urandom), 250, 1'b0);
    run_phase('1, 200, 1'b0);
    run_phase('0, 100, 1'b0);
    run_flood(300);
    run_phase(32'($urandom_range(100000, 100000000)), 250, 1'($urandom_range(0, 1)));

    drain();
    repeat (TailCycles) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
